/* hdl/bsl_pkg.sv */
`timescale 1ns / 1ps

package bsl_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned FIDX_W  = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned GROUP_W = 8;   // match bits examined per scan cycle

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_POP_BACK   = 3'd1,
    KIND_PUSH_FRONT = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_INSERT     = 3'd4,
    KIND_ERASE      = 3'd5,
    KIND_FIND       = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  // Broadcast command to every cell of the row.
  typedef struct packed {
    logic shift_up;    // open a gap at pos, write data there
    logic shift_down;  // close the gap at pos
  } cell_op_t;

endpackage

/* hdl/bsl_cell.sv */
`timescale 1ns / 1ps

module bsl_cell import bsl_pkg::*; #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CMPW = 8
) (
  input  logic              clk_i,
  input  cell_op_t          op_i,
  input  logic [CMPW-1:0]   pos_i,
  input  logic [CMPW-1:0]   count_i,
  input  logic [DATA_W-1:0] data_i,   // value to write, or key to compare
  input  logic [DATA_W-1:0] prev_i,   // entry of the lower neighbor
  input  logic [DATA_W-1:0] next_i,   // entry of the upper neighbor
  output logic [DATA_W-1:0] entry_o,
  output logic              hit_o
);

  localparam logic [CMPW-1:0] IdxV = CMPW'(IDX);

  logic [DATA_W-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (op_i.shift_up) begin
      if (IdxV == pos_i) begin
        entry_d = data_i;
      end else if (IdxV > pos_i) begin
        entry_d = prev_i;
      end
    end else if (op_i.shift_down) begin
      if (IdxV >= pos_i) begin
        entry_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // Only live entries may match.
  assign hit_o   = (entry_q == data_i) && (IdxV < count_i);

endmodule

/* hdl/bounded_sequential_list.sv */
`timescale 1ns / 1ps
// Bounded ordered list of signed 32-bit values, CAPACITY entries deep.
// Slave stream: one transaction carries one operation; tuser holds the kind
// (push back, pop back, push front, pop front, insert, erase, find), tdata
// holds the position and the value. Master stream: one transaction per
// operation with status, found flag, found index and the new element count.
// Entries live in a row of cells; insert and erase shift every later entry
// by one place together, and all cells compare against a find key at once.
// Every operation but find has its result on the master side the cycle after
// acceptance. A find registers the match bits of all cells in the acceptance
// cycle, then scans them eight entries per cycle, stopping at the first group
// with a match or at the count, and loads its result once the output register
// is free.
// Throughput: one operation every cycle for non-find operations while the
// result is taken; a find holds off the next transaction until its scan ends.
// Reset clears the count (empty list) and the output valid. The result sits
// in an output register; a stalled receiver holds it, and the next
// transaction is accepted as soon as that register is free or being drained.
module bounded_sequential_list import bsl_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [1:0] status, [2] found,
                                      // [8:3] found_index, [15:9] count
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int unsigned NGRP = (CAPACITY + GROUP_W - 1) / GROUP_W;
  localparam int unsigned HW   = NGRP * GROUP_W;

  // ---------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_value;
  kind_e             in_kind;
  logic              in_acc;

  assign in_pos   = s_axis_tdata[POS_W-1:0];
  assign in_value = s_axis_tdata[POS_W +: DATA_W];
  assign in_kind  = kind_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_e          st_q, st_d;
  logic [CW-1:0]   count_q, count_d;
  logic            m_valid_q, m_valid_d;
  logic            out_free;

  // Output register payload
  status_e         o_status_q;
  logic            o_found_q;
  logic [FIDX_W-1:0] o_fidx_q;
  logic [CNT_W-1:0]  o_count_q;

  // Find scan
  logic [HW-1:0]   hit_q, hit_d;
  logic [CMPW-1:0] base_q, base_d;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && out_free;

  // ---------------------------------------------------------------------
  // Operation decode, done in the acceptance cycle
  // ---------------------------------------------------------------------
  logic [CMPW-1:0] cnt_w, pos_w, cell_pos;
  logic            is_full, is_empty, op_ok, grow, shrink;
  status_e         op_status;
  cell_op_t        cell_op;

  assign cnt_w    = CMPW'(count_q);
  assign pos_w    = CMPW'(in_pos);
  assign is_full  = (cnt_w == CMPW'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    op_status = STATUS_OK;
    grow      = 1'b0;
    shrink    = 1'b0;
    cell_pos  = pos_w;
    cell_op   = '0;
    unique case (in_kind)
      KIND_PUSH_BACK: begin
        cell_pos = cnt_w;
        if (is_full) begin
          op_status = STATUS_FULL;
        end else begin
          grow             = 1'b1;
          cell_op.shift_up = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (is_empty) begin
          op_status = STATUS_EMPTY;
        end else begin
          shrink = 1'b1;
        end
      end
      KIND_PUSH_FRONT: begin
        cell_pos = '0;
        if (is_full) begin
          op_status = STATUS_FULL;
        end else begin
          grow             = 1'b1;
          cell_op.shift_up = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        cell_pos = '0;
        if (is_empty) begin
          op_status = STATUS_EMPTY;
        end else begin
          shrink             = 1'b1;
          cell_op.shift_down = 1'b1;
        end
      end
      KIND_INSERT: begin
        // range check takes precedence over full
        if (pos_w > cnt_w) begin
          op_status = STATUS_RANGE;
        end else if (is_full) begin
          op_status = STATUS_FULL;
        end else begin
          grow             = 1'b1;
          cell_op.shift_up = 1'b1;
        end
      end
      KIND_ERASE: begin
        if (is_empty) begin
          op_status = STATUS_EMPTY;
        end else if (pos_w >= cnt_w) begin
          op_status = STATUS_RANGE;
        end else begin
          shrink             = 1'b1;
          cell_op.shift_down = 1'b1;
        end
      end
      KIND_FIND: begin
        op_status = STATUS_OK;
      end
      default: begin
        op_status = STATUS_OK;   // unused kind: no change
      end
    endcase
    if (!in_acc) begin
      cell_op = '0;
    end
    op_ok = (op_status == STATUS_OK);
  end

  // ---------------------------------------------------------------------
  // Row of cells
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0] hits;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = ent[i+1];
    end
    bsl_cell #(
      .IDX  (i),
      .CMPW (CMPW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .pos_i   (cell_pos),
      .count_i (cnt_w),
      .data_i  (in_value),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .entry_o (ent[i]),
      .hit_o   (hits[i])
    );
  end

  // ---------------------------------------------------------------------
  // Find scan: eight match bits per cycle
  // ---------------------------------------------------------------------
  logic [GROUP_W-1:0] grp;
  logic [2:0]         penc;
  logic               grp_any, scan_last, scan_done;
  logic [CMPW-1:0]    base_next, fidx_w;

  assign grp       = hit_q[GROUP_W-1:0];
  assign grp_any   = |grp;
  assign base_next = base_q + CMPW'(GROUP_W);
  assign scan_last = (base_next >= cnt_w);
  assign scan_done = grp_any || scan_last;
  assign fidx_w    = base_q + CMPW'(penc);

  always_comb begin
    penc = '0;
    for (int j = GROUP_W - 1; j >= 0; j--) begin
      if (grp[j]) begin
        penc = 3'(j);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing and output register
  // ---------------------------------------------------------------------
  logic              out_load;
  status_e           o_status_d;
  logic              o_found_d;
  logic [FIDX_W-1:0] o_fidx_d;
  logic [CW-1:0]     res_count;
  logic [CMPW-1:0]   res_count_w;

  always_comb begin
    st_d       = st_q;
    count_d    = count_q;
    hit_d      = hit_q;
    base_d     = base_q;
    out_load   = 1'b0;
    o_status_d = op_status;
    o_found_d  = 1'b0;
    o_fidx_d   = '0;
    res_count  = count_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_FIND) begin
            hit_d  = HW'(hits);
            base_d = '0;
            st_d   = ST_SCAN;
          end else begin
            if (op_ok && grow) begin
              count_d = count_q + CW'(1);
            end else if (op_ok && shrink) begin
              count_d = count_q - CW'(1);
            end
            res_count = count_d;
            out_load  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        o_status_d = STATUS_OK;
        if (scan_done) begin
          if (out_free) begin
            out_load  = 1'b1;
            o_found_d = grp_any;
            o_fidx_d  = grp_any ? fidx_w[FIDX_W-1:0] : '0;
            st_d      = ST_IDLE;
          end
        end else begin
          hit_d  = hit_q >> GROUP_W;
          base_d = base_next;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
    m_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);
  end

  assign res_count_w = CMPW'(res_count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    base_q <= base_d;
    if (out_load) begin
      o_status_q <= o_status_d;
      o_found_q  <= o_found_d;
      o_fidx_q   <= o_fidx_d;
      o_count_q  <= res_count_w[CNT_W-1:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {o_count_q, o_fidx_q, o_found_q, o_status_q};

endmodule

/* hdl/bsl_checker.sv */
`timescale 1ns / 1ps

module bsl_checker import bsl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Input is only taken when the output register can accept the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("bsl: input ready while result stalled");

  // Every operation other than find answers on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != KIND_FIND)) |=> m_axis_tvalid)
    else $error("bsl: missing result one cycle after transaction");

  // A failed operation reports no match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] != STATUS_OK)) |-> (m_axis_tdata[8:2] == '0))
    else $error("bsl: match fields set on failed operation");

  // No match means index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[8:3] == '0))
    else $error("bsl: nonzero index without match");

  // Stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("bsl: stalled result changed");

endmodule

bind bounded_sequential_list bsl_checker u_bsl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bsl_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;  // watchdog, far above the slowest run
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_AFTER   = 70;      // ops accepted before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 300;

  // kind 7 is outside kind_e; the block must answer it as a no-op
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } list_op_t;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [FIDX_W-1:0] fidx;
    logic [CNT_W-1:0]  count;
  } list_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [6:0] position, [38:7] value, [39] zero
  logic [2:0]  s_axis_tuser = '0;   // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [1:0] status, [2] found, [8:3] found_index,
                                    // [15:9] count

  // Contents of the list as the block should hold them. The stimulus builder
  // walks it once to pick sensible positions and keys, then it is cleared
  // and walked again, in step with the transactions the block accepts.
  logic [DATA_W-1:0] list_model[$];
  list_op_t          pending_ops[$];   // operations waiting to be offered
  list_res_t         due_results[$];   // results owed by the block, oldest first

  int unsigned ops_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // sender side
  list_op_t    drv_op;
  logic        drv_offer;
  int unsigned gap_left = 0;
  int unsigned in_quiet = 0;

  // receiver side
  list_res_t   mon_got;
  list_res_t   mon_want;
  logic        mon_rdy;
  int unsigned stall_left = 0;
  int unsigned out_quiet = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  bounded_sequential_list #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Applies one operation to list_model and returns what the block must answer.
  // Order of checks matters: insert rejects a bad position before a full list,
  // erase reports an empty list before a bad position.
  function automatic list_res_t apply_list_op(list_op_t op);
    list_res_t   res;
    int unsigned n;
    int unsigned i;
    res = '0;
    res.status = STATUS_OK;
    n = list_model.size();
    case (op.kind)
      KIND_PUSH_BACK: begin
        if (n >= CAPACITY) res.status = STATUS_FULL;
        else list_model.push_back(op.value);
      end
      KIND_PUSH_FRONT: begin
        if (n >= CAPACITY) res.status = STATUS_FULL;
        else list_model.push_front(op.value);
      end
      KIND_POP_BACK: begin
        if (n == 0) res.status = STATUS_EMPTY;
        else void'(list_model.pop_back());
      end
      KIND_POP_FRONT: begin
        if (n == 0) res.status = STATUS_EMPTY;
        else void'(list_model.pop_front());
      end
      KIND_INSERT: begin
        if (op.pos > n) res.status = STATUS_RANGE;
        else if (n >= CAPACITY) res.status = STATUS_FULL;
        else list_model.insert(op.pos, op.value);
      end
      KIND_ERASE: begin
        if (n == 0) res.status = STATUS_EMPTY;
        else if (op.pos >= n) res.status = STATUS_RANGE;
        else list_model.delete(op.pos);
      end
      KIND_FIND: begin
        // lowest matching index wins; no match leaves found and index at zero
        for (i = 0; i < n; i++) begin
          if (list_model[i] == op.value) begin
            res.found = 1'b1;
            res.fidx = FIDX_W'(i);
            break;
          end
        end
      end
      default: ;  // unused kind: nothing changes
    endcase
    res.count = CNT_W'(list_model.size());
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A small pool makes duplicate keys likely, so find has to pick the first.
  function automatic logic [DATA_W-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(0, 7);
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                        input logic [DATA_W-1:0] value);
    list_op_t op;
    op.kind = kind;
    op.pos = pos;
    op.value = value;
    pending_ops.push_back(op);
    void'(apply_list_op(op));
  endtask

  // Random operations biased toward growing or shrinking the list, or mixed, so both the
  // full and the empty list are reached. Positions and keys are mostly valid
  // for the list as it will be; the rest are out of range or random.
  task automatic gen_phase(input phase_e mode, input int unsigned len);
    int unsigned       add_pct;
    int unsigned       rem_pct;
    int unsigned       r;
    int unsigned       n;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    add_pct = (mode == PH_GROW) ? 80 : (mode == PH_SHRINK) ? 10 : 40;
    rem_pct = (mode == PH_GROW) ? 8 : (mode == PH_SHRINK) ? 78 : 35;
    repeat (len) begin
      n = list_model.size();
      r = $urandom_range(0, 99);
      pos = POS_W'($urandom_range(0, 127));   // ignored field for most kinds, still toggles
      value = rand_value();
      if (r < add_pct) begin
        case ($urandom_range(0, 2))
          0: kind = KIND_PUSH_BACK;
          1: kind = KIND_PUSH_FRONT;
          default: begin
            kind = KIND_INSERT;
            if ($urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, n));
          end
        endcase
      end else if (r < add_pct + rem_pct) begin
        case ($urandom_range(0, 2))
          0: kind = KIND_POP_BACK;
          1: kind = KIND_POP_FRONT;
          default: begin
            kind = KIND_ERASE;
            if (n != 0 && $urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, n - 1));
          end
        endcase
      end else if (r < 98) begin
        kind = KIND_FIND;
        if (n != 0 && $urandom_range(0, 9) < 7) value = list_model[$urandom_range(0, n - 1)];
      end else begin
        kind = KIND_UNUSED;
      end
      add_op(kind, pos, value);
    end
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Sender: offers pending_ops in order. The expected result is computed at
  // the edge where the transaction is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      drv_offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        drv_op = pending_ops.pop_front();
        due_results.push_back(apply_list_op(drv_op));
        ops_accepted++;
        drv_offer = 1'b0;
        if (in_quiet > 0) begin
          in_quiet--;
          gap_left = 0;
        end else begin
          gap_left = draw_gap();
          if ($urandom_range(0, 39) == 0) in_quiet = $urandom_range(20, 60);
        end
      end
      if (!drv_offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          s_axis_tdata <= {1'b0, pending_ops[0].value, pending_ops[0].pos};
          s_axis_tuser <= pending_ops[0].kind;
          drv_offer = 1'b1;
        end
      end
      s_axis_tvalid <= drv_offer;
    end
  end

  // One long hold-off on the result side while the sender keeps offering,
  // so the output register fills and the block has to drop tready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && ops_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each result transaction against the oldest one owed,
  // then decides tready for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        mon_got.status = status_e'(m_axis_tdata[1:0]);
        mon_got.found = m_axis_tdata[2];
        mon_got.fidx = m_axis_tdata[8:3];
        mon_got.count = m_axis_tdata[15:9];
        if (due_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time,
                   m_axis_tdata);
          mismatches++;
        end else begin
          mon_want = due_results.pop_front();
          check_field("status", 8'(mon_want.status), 8'(mon_got.status));
          check_field("found", 8'(mon_want.found), 8'(mon_got.found));
          check_field("found_index", 8'(mon_want.fidx), 8'(mon_got.fidx));
          check_field("count", 8'(mon_want.count), 8'(mon_got.count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        mon_rdy = 1'b0;
      end else if (out_quiet > 0) begin
        out_quiet--;
        mon_rdy = 1'b1;
      end else begin
        mon_rdy = 1'b1;
        case ($urandom_range(0, 49))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: stall_left = 1 + draw_gap();
          10: out_quiet = $urandom_range(30, 90);
          default: ;
        endcase
      end
      m_axis_tready <= mon_rdy && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    // directed: empty-list errors, unused kind, value extremes, position
    // extremes, find with first match, last entry and no match
    add_op(KIND_POP_BACK, 7'd0, 32'h0);
    add_op(KIND_POP_FRONT, 7'd127, 32'hffff_ffff);
    add_op(KIND_ERASE, 7'd0, 32'h0);
    add_op(KIND_FIND, 7'd0, 32'h0);               // find on empty list
    add_op(KIND_INSERT, 7'd1, 32'h1234_5678);     // position past count
    add_op(KIND_UNUSED, 7'd127, 32'hffff_ffff);
    add_op(KIND_PUSH_BACK, 7'd0, 32'h7fff_ffff);
    add_op(KIND_PUSH_FRONT, 7'd0, 32'h8000_0000);
    add_op(KIND_INSERT, 7'd1, 32'hffff_ffff);
    add_op(KIND_INSERT, 7'd3, 32'h0000_0000);     // insert at count appends
    add_op(KIND_INSERT, 7'd0, 32'h7fff_ffff);     // duplicate further down
    add_op(KIND_FIND, 7'd0, 32'h7fff_ffff);       // first match wins
    add_op(KIND_FIND, 7'd0, 32'h0000_0000);       // last entry
    add_op(KIND_FIND, 7'd0, 32'h0bad_cafe);       // no match
    add_op(KIND_UNUSED, 7'd0, 32'h0);
    add_op(KIND_ERASE, 7'd5, 32'h0);              // position at count
    add_op(KIND_ERASE, 7'd127, 32'h0);
    add_op(KIND_INSERT, 7'd127, 32'h5555_aaaa);
    add_op(KIND_INSERT, 7'd64, 32'haaaa_5555);
    add_op(KIND_ERASE, 7'd1, 32'h0);
    add_op(KIND_POP_FRONT, 7'd0, 32'h0);
    add_op(KIND_POP_BACK, 7'd0, 32'h0);
    add_op(KIND_ERASE, 7'd2, 32'h0);              // position at count

    gen_phase(PH_GROW, 110);
    gen_phase(PH_SHRINK, 110);
    gen_phase(PH_GROW, 100);
    gen_phase(PH_MIXED, 80);

    // back to the post-reset list before the real walk starts
    list_model.delete();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
